// ===== rtl/tausworthe_223_random_source_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the combined Tausworthe random source
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TAUSWORTHE_223_RANDOM_SOURCE_CORE_MACROS_SVH
`define TAUSWORTHE_223_RANDOM_SOURCE_CORE_MACROS_SVH

// check while out of reset
`define TW223_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tw223 check failed");

// check at every edge, reset included
`define TW223_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("tw223 check failed");

`endif

// ===== rtl/tw223_pkg.sv =====
// ----------------------------------------------------------------------------
// tw223_pkg
// Types, constants and step functions of the combined Tausworthe source.
// ----------------------------------------------------------------------------
`default_nettype none

package tw223_pkg;

  localparam int unsigned NumGen             = 4;
  localparam int unsigned WordW              = 64;
  localparam int unsigned FracW              = 52;
  localparam int unsigned HalfW              = 26;
  localparam int unsigned IntW               = 32;
  localparam int unsigned WarmupStepsDefault = 10;

  localparam logic [1:0] ModeRaw    = 2'd0;
  localparam logic [1:0] ModeUnit   = 2'd1;
  localparam logic [1:0] ModeRange  = 2'd2;
  localparam logic [1:0] ModeReseed = 2'd3;

  localparam logic [1:0] CfgSeedA = 2'd0;
  localparam logic [1:0] CfgSeedB = 2'd1;
  localparam logic [1:0] CfgSeedC = 2'd2;
  localparam logic [1:0] CfgSeedD = 2'd3;

  localparam int unsigned GenK [NumGen] = '{63, 58, 55, 47};
  localparam int unsigned GenQ [NumGen] = '{31, 19, 24, 21};
  localparam int unsigned GenS [NumGen] = '{18, 28, 7, 8};

  typedef logic [NumGen-1:0][WordW-1:0] gens_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [IntW-1:0] range_low;
    logic signed [IntW-1:0] range_high;
  } req_t;

  typedef struct packed {
    logic [FracW-1:0]       fraction;
    logic signed [IntW-1:0] int_value;
    logic                   range_error;
  } rsp_t;

  function automatic logic [WordW-1:0] tw_step(logic [WordW-1:0] z, int unsigned k,
                                               int unsigned q, int unsigned s);
    logic [WordW-1:0] keep;
    keep = z & ({WordW{1'b1}} << (WordW - k));
    return (((z << q) ^ z) >> (k - s)) ^ (keep << s);
  endfunction

  function automatic gens_t gens_step(gens_t g);
    gens_t n;
    for (int i = 0; i < NumGen; i++) begin
      n[i] = tw_step(g[i], GenK[i], GenQ[i], GenS[i]);
    end
    return n;
  endfunction

  // force a nonzero top part into each word
  function automatic gens_t seed_fix(gens_t w);
    gens_t            f;
    logic [WordW-1:0] m;
    for (int i = 0; i < NumGen; i++) begin
      m = WordW'(1) << (WordW - GenK[i]);
      f[i] = (w[i] < m) ? (w[i] | m) : w[i];
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tausworthe_223_random_source_core.sv =====
// ----------------------------------------------------------------------------
// tausworthe_223_random_source_core
// Combined four-word Tausworthe random source with raw and scaled draws.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  request | in_valid_i / in_ready_o | in_data_i  (mode, range bounds)
//  result  | out_valid_o/out_ready_i | out_data_o (fraction, int, error)
//  config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One draw per cycle while the result moves and no warm-up runs; a request
//  passes the request register, two scaling stages and the result register.
//  A reseed request, and the first request after reset, loads the seeds;
//  warm-up then holds the draw that follows. A stalled result freezes the
//  scaling pipeline; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tausworthe_223_random_source_core #(
  parameter int unsigned WARMUP_STEPS = tw223_pkg::WarmupStepsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tw223_pkg::req_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tw223_pkg::rsp_t                     out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [tw223_pkg::WordW-1:0]         cfg_data_i
);
  import tw223_pkg::*;

  localparam int unsigned CntW = $clog2(WARMUP_STEPS + 2);
  localparam int unsigned SpanW = IntW + 1;
  localparam int unsigned ProdW = HalfW + SpanW;

  gens_t                  seed_q;
  gens_t                  gen_q, gen_d, gen_next;
  logic                   seeded_q, seeded_d;
  logic [CntW-1:0]        warm_q, warm_d;
  logic                   v0_q, v0_d;
  req_t                   req0_q;
  logic                   v1_q, v2_q, out_valid_q;
  logic [FracW-1:0]       frac1_q, frac2_q, frac_now;
  logic [1:0]             kind1_q, kind2_q;
  logic signed [IntW-1:0] lo1_q, lo2_q, lo_now;
  logic                   err1_q, err2_q, err_now;
  logic [SpanW-1:0]       span1_q;
  logic [ProdW-1:0]       pph_q, ppl_q;
  rsp_t                   out_q, out_d;

  logic                   warm_busy, need_seed, draw_fire, reseed_drop, en, in_fire;
  logic signed [SpanW:0]  span_now;
  logic [ProdW:0]         acc;
  logic [IntW-1:0]        qnt;

  assign gen_next = gens_step(gen_q);

  always_comb begin
    frac_now = '0;
    for (int i = 0; i < NumGen; i++) begin
      frac_now = frac_now ^ gen_next[i][FracW-1:0];
    end
  end

  assign warm_busy   = (warm_q != '0);
  assign need_seed   = v0_q && !warm_busy && (req0_q.mode == ModeReseed || !seeded_q);
  assign en          = !out_valid_q || out_ready_i;
  assign draw_fire   = v0_q && !warm_busy && !need_seed && en;
  assign reseed_drop = need_seed && (req0_q.mode == ModeReseed);
  assign in_ready_o  = !v0_q || draw_fire || reseed_drop;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // span and its sign and zero check
  always_comb begin
    if (req0_q.mode == ModeUnit) begin
      lo_now   = IntW'(1);
      span_now = (SpanW+1)'(req0_q.range_high);
    end else begin
      lo_now   = req0_q.range_low;
      span_now = (SpanW+1)'(req0_q.range_high) - (SpanW+1)'(req0_q.range_low)
                 + (SpanW+1)'(1);
    end
    err_now = span_now[SpanW] || (span_now == '0);
  end

  always_comb begin
    gen_d    = gen_q;
    seeded_d = seeded_q;
    warm_d   = warm_q;
    if (v0_q && warm_busy) begin
      gen_d  = gen_next;
      warm_d = warm_q - CntW'(1);
    end else if (need_seed) begin
      gen_d    = seed_fix(seed_q);
      seeded_d = 1'b1;
      warm_d   = CntW'(WARMUP_STEPS);
    end else if (draw_fire) begin
      gen_d = gen_next;
    end
  end

  always_comb begin
    v0_d = v0_q;
    if (in_fire) begin
      v0_d = 1'b1;
    end else if (draw_fire || reseed_drop) begin
      v0_d = 1'b0;
    end
  end

  // final scaling
  always_comb begin
    acc = (ProdW+1)'(pph_q) + (ProdW+1)'(ppl_q >> HalfW);
    qnt = acc[HalfW +: IntW];
    out_d.fraction    = frac2_q;
    out_d.int_value   = '0;
    out_d.range_error = 1'b0;
    if (kind2_q != ModeRaw) begin
      out_d.range_error = err2_q;
      out_d.int_value   = err2_q ? lo2_q : (lo2_q + $signed(qnt));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      gen_q       <= '0;
      seeded_q    <= 1'b0;
      warm_q      <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgSeedA: seed_q[0] <= cfg_data_i;
          CfgSeedB: seed_q[1] <= cfg_data_i;
          CfgSeedC: seed_q[2] <= cfg_data_i;
          CfgSeedD: seed_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      gen_q    <= gen_d;
      seeded_q <= seeded_d;
      warm_q   <= warm_d;
      v0_q     <= v0_d;
      if (en) begin
        v1_q        <= draw_fire;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req0_q <= in_data_i;
    end
    if (en) begin
      frac1_q <= frac_now;
      kind1_q <= req0_q.mode;
      lo1_q   <= lo_now;
      err1_q  <= err_now;
      span1_q <= span_now[SpanW-1:0];
      frac2_q <= frac1_q;
      kind2_q <= kind1_q;
      lo2_q   <= lo1_q;
      err2_q  <= err1_q;
      pph_q   <= {{SpanW{1'b0}}, frac1_q[FracW-1:HalfW]} * {{HalfW{1'b0}}, span1_q};
      ppl_q   <= {{SpanW{1'b0}}, frac1_q[HalfW-1:0]} * {{HalfW{1'b0}}, span1_q};
      out_q   <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/tw223_checker.sv =====
// ----------------------------------------------------------------------------
// tw223_checker
// Port-level checks of the combined Tausworthe random source.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tausworthe_223_random_source_core_macros.svh"

module tw223_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input tw223_pkg::rsp_t out_data_o,
  input logic            cfg_ready_o
);

  `TW223_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `TW223_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_valid_o)
  `TW223_ASSERT(a_cfg_ready, cfg_ready_o)

endmodule

bind tausworthe_223_random_source_core tw223_checker u_tw223_checker (.*);

`default_nettype wire
